>>> hdl/escape_framed_packet_deframer_assert.svh
// Assertion macros for the escape-framed packet deframer.
// Expect signals clk and rst_n in the scope of use.
`ifndef ESCAPE_FRAMED_PACKET_DEFRAMER_ASSERT_SVH
`define ESCAPE_FRAMED_PACKET_DEFRAMER_ASSERT_SVH
`ifndef SYNTH
`define EFPD_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("deframer invariant violated");
`define EFPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer implication violated");
`define EFPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer next-cycle check violated");
`else
`define EFPD_ASSERT_ALWAYS(label, expr)
`define EFPD_ASSERT_IMPL(label, ante, cons)
`define EFPD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/efpd_pkg.sv
// Shared types and constants for the escape-framed packet deframer.
// No dependencies.
package efpd_pkg;

  localparam logic [7:0]  ESC_BYTE      = 8'd27;
  localparam logic [7:0]  LOW_BYTE      = 8'd32;
  localparam logic [7:0]  HIGH_BYTE     = 8'd95;
  localparam logic [3:0]  FRAME_LEN     = 4'd11;
  localparam logic [3:0]  POS_IDLE      = 4'd0;
  localparam logic [3:0]  POS_FIRST     = 4'd1;
  localparam logic [23:0] TIMEOUT_RESET = 24'd3000;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_PASS    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pass_byte;
    logic [31:0] stamp;
    logic [1:0]  repair_count;
    logic [31:0] bus_packet;
  } result_t;

endpackage

>>> hdl/efpd_core.sv
// Deframer state machine: frame position, field accumulators, idle tick counter.
// Depends on efpd_pkg and the assertion macro header.
`include "escape_framed_packet_deframer_assert.svh"

module efpd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [23:0]      cfg_wdata,
  input  logic             step_en,
  input  efpd_pkg::item_t  item,
  output logic             res_valid,
  output efpd_pkg::result_t res
);

  logic [23:0] timeout_r;
  logic [3:0]  pos_r,   pos_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [1:0]  rep_r,   rep_nxt;
  logic [31:0] pkt_r,   pkt_nxt;
  logic [23:0] idle_r,  idle_nxt;

  logic        in_frame;
  logic [5:0]  digit;
  logic [23:0] idle_inc;
  logic [31:0] stamp_new, pkt_new;
  logic [1:0]  rep_new;

  assign in_frame = (pos_r >= efpd_pkg::POS_FIRST) && (pos_r <= efpd_pkg::FRAME_LEN);
  assign digit    = 6'(item.rx_byte - efpd_pkg::LOW_BYTE);
  assign idle_inc = idle_r + 24'd1;

  // Merge one frame digit into the accumulators at the current position.
  always_comb begin
    stamp_new = stamp_r;
    rep_new   = rep_r;
    pkt_new   = pkt_r;
    case (pos_r)
      4'd1: stamp_new = stamp_r | {26'd0, digit};
      4'd2: stamp_new = stamp_r | {20'd0, digit, 6'd0};
      4'd3: stamp_new = stamp_r | {14'd0, digit, 12'd0};
      4'd4: stamp_new = stamp_r | {8'd0, digit, 18'd0};
      4'd5: stamp_new = stamp_r | {2'd0, digit, 24'd0};
      4'd6: begin
        stamp_new = stamp_r | {digit[1:0], 30'd0};
        rep_new   = digit[3:2];
        pkt_new   = pkt_r | {30'd0, digit[5:4]};
      end
      4'd7:  pkt_new = pkt_r | {24'd0, digit, 2'd0};
      4'd8:  pkt_new = pkt_r | {18'd0, digit, 8'd0};
      4'd9:  pkt_new = pkt_r | {12'd0, digit, 14'd0};
      4'd10: pkt_new = pkt_r | {6'd0, digit, 20'd0};
      default: pkt_new = pkt_r | {digit, 26'd0};
    endcase
  end

  always_comb begin
    pos_nxt   = pos_r;
    stamp_nxt = stamp_r;
    rep_nxt   = rep_r;
    pkt_nxt   = pkt_r;
    idle_nxt  = idle_r;
    res_valid = 1'b0;
    res       = '0;
    if (!in_frame) begin
      pos_nxt = efpd_pkg::POS_IDLE;
    end

    if (item.mode == efpd_pkg::MODE_TICK) begin
      if (in_frame) begin
        idle_nxt = idle_inc;
        if (idle_inc >= timeout_r) begin
          res_valid        = 1'b1;
          res.kind         = efpd_pkg::KIND_TIMEOUT;
          res.stamp        = stamp_r;
          res.repair_count = rep_r;
          res.bus_packet   = pkt_r;
          pos_nxt   = efpd_pkg::POS_IDLE;
          stamp_nxt = '0;
          rep_nxt   = '0;
          pkt_nxt   = '0;
          idle_nxt  = '0;
        end
      end
    end else if (!in_frame) begin
      if (item.rx_byte == efpd_pkg::ESC_BYTE) begin
        pos_nxt   = efpd_pkg::POS_FIRST;
        stamp_nxt = '0;
        rep_nxt   = '0;
        pkt_nxt   = '0;
        idle_nxt  = '0;
      end else begin
        res_valid     = 1'b1;
        res.kind      = efpd_pkg::KIND_PASS;
        res.pass_byte = item.rx_byte;
      end
    end else if (!(item.rx_byte inside {[efpd_pkg::LOW_BYTE:efpd_pkg::HIGH_BYTE]})) begin
      res_valid        = 1'b1;
      res.kind         = efpd_pkg::KIND_BAD;
      res.stamp        = stamp_r;
      res.repair_count = rep_r;
      res.bus_packet   = pkt_r;
      pos_nxt   = efpd_pkg::POS_IDLE;
      stamp_nxt = '0;
      rep_nxt   = '0;
      pkt_nxt   = '0;
      idle_nxt  = '0;
    end else begin
      idle_nxt = '0;
      if (pos_r == efpd_pkg::FRAME_LEN) begin
        res_valid        = 1'b1;
        res.kind         = efpd_pkg::KIND_DONE;
        res.stamp        = stamp_new;
        res.repair_count = rep_new;
        res.bus_packet   = pkt_new;
        pos_nxt   = efpd_pkg::POS_IDLE;
        stamp_nxt = '0;
        rep_nxt   = '0;
        pkt_nxt   = '0;
      end else begin
        pos_nxt   = pos_r + 4'd1;
        stamp_nxt = stamp_new;
        rep_nxt   = rep_new;
        pkt_nxt   = pkt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= efpd_pkg::TIMEOUT_RESET;
      pos_r     <= efpd_pkg::POS_IDLE;
      stamp_r   <= '0;
      rep_r     <= '0;
      pkt_r     <= '0;
      idle_r    <= '0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (step_en) begin
        pos_r   <= pos_nxt;
        stamp_r <= stamp_nxt;
        rep_r   <= rep_nxt;
        pkt_r   <= pkt_nxt;
        idle_r  <= idle_nxt;
      end
    end
  end

  `EFPD_ASSERT_ALWAYS(a_pos_range, pos_r <= efpd_pkg::FRAME_LEN)
  `EFPD_ASSERT_IMPL(a_idle_clear_outside, pos_r == efpd_pkg::POS_IDLE, idle_r == '0)
  `EFPD_ASSERT_IMPL(a_pass_outside, res_valid && res.kind == efpd_pkg::KIND_PASS, !in_frame)
  `EFPD_ASSERT_NEXT(a_end_clears, step_en && res_valid && res.kind != efpd_pkg::KIND_PASS,
                    pos_r == efpd_pkg::POS_IDLE && stamp_r == '0 && pkt_r == '0)

endmodule

>>> hdl/efpd_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on efpd_pkg.
module efpd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  efpd_pkg::result_t load_res,
  input  logic              out_ready,
  output logic              can_load,
  output logic              out_valid,
  output efpd_pkg::result_t out_res
);

  logic              valid_r;
  efpd_pkg::result_t res_r;

  // Space when empty or when the held result leaves this cycle.
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_r <= load_res;
    end
  end

endmodule

>>> hdl/escape_framed_packet_deframer.sv
// Escape-framed packet deframer: input register, framing core, result register.
// Order: input register, combinational core update, result register.
// Throughput: one input request per cycle while the result side is taken each cycle;
//   the combinational core update between input and result registers sets this.
// Reset (synchronous, rst_n low): no frame open, accumulators and idle count zero,
//   timeout register 3000, both registers empty.
module escape_framed_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_pass_byte,
  output logic [31:0] out_stamp,
  output logic [1:0]  out_repair_count,
  output logic [31:0] out_bus_packet
);

  logic              in_valid_r;
  efpd_pkg::item_t   item_r;
  logic              step_en;
  logic              can_load;
  logic              res_valid;
  efpd_pkg::result_t res;
  efpd_pkg::result_t out_res;

  assign step_en  = in_valid_r && can_load;
  assign in_ready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.mode    <= in_mode;
      item_r.rx_byte <= in_rx_byte;
    end
  end

  efpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .item      (item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  efpd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && res_valid),
    .load_res  (res),
    .out_ready (out_ready),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_pass_byte    = out_res.pass_byte;
  assign out_stamp        = out_res.stamp;
  assign out_repair_count = out_res.repair_count;
  assign out_bus_packet   = out_res.bus_packet;

endmodule
